FILE: rtl/core/rbd_pkg.sv
// ----------------------------------------------------------------------------
// rbd_pkg
// Shared types and constants of the ring buffer deque: command codes,
// request and response payloads, controller to datapath commands.
// ----------------------------------------------------------------------------
`default_nettype none

package rbd_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 32;

	typedef enum logic [1:0] {
		CMD_PUSH_FRONT = 2'd0,
		CMD_PUSH_BACK  = 2'd1,
		CMD_POP_FRONT  = 2'd2,
		CMD_POP_BACK   = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t        command;
		logic [31:0] item_value;
	} req_t;

	typedef struct packed {
		logic [31:0] popped_value;
		logic        ok;
		logic [4:0]  item_count;
		logic        is_empty;
		logic        is_full;
	} rsp_t;

	typedef struct packed {
		logic accept;
		logic load_pop;
	} ctl_t;

endpackage

`default_nettype wire

FILE: rtl/core/rbd_ctrl.sv
// ----------------------------------------------------------------------------
// rbd_ctrl
// Controller: takes one request at a time, waits in ST_READ for the slot
// read of a pop, and owns the response valid.
// ----------------------------------------------------------------------------
`default_nettype none

module rbd_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire rbd_pkg::cmd_t req_command,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output rbd_pkg::ctl_t      ctl
);
	import rbd_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   accept;
	logic   is_pop;

	assign req_stall = (state_q != ST_IDLE) || (rsp_valid_q && rsp_stall);
	assign accept    = req_valid && !req_stall;
	assign is_pop    = (req_command == CMD_POP_FRONT) || (req_command == CMD_POP_BACK);

	assign ctl.accept   = accept;
	assign ctl.load_pop = (state_q == ST_READ);
	assign rsp_valid    = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && is_pop) begin
						state_q     <= ST_READ;
						rsp_valid_q <= 1'b0;
					end else if (accept) begin
						rsp_valid_q <= 1'b1;
					end else if (rsp_valid_q && !rsp_stall) begin
						rsp_valid_q <= 1'b0;
					end
				end
				ST_READ: begin
					state_q     <= ST_IDLE;
					rsp_valid_q <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/rbd_datapath.sv
// ----------------------------------------------------------------------------
// rbd_datapath
// Datapath: front and back indices, empty flag, entry count, slot memory
// with registered read, and the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module rbd_datapath #(
	parameter int DEPTH      = rbd_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = rbd_pkg::DATA_WIDTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire rbd_pkg::ctl_t ctl,
	input  wire rbd_pkg::req_t req,
	output rbd_pkg::rsp_t      rsp
);
	import rbd_pkg::*;

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [IW-1:0] LAST  = IW'(DEPTH - 1);
	localparam logic [CW-1:0] FULLC = CW'(DEPTH);

	logic [DATA_WIDTH-1:0] mem [DEPTH];
	logic [DATA_WIDTH-1:0] rd_q;

	logic [IW-1:0] front_q, back_q;
	logic          empty_q;
	logic [CW-1:0] count_q;
	rsp_t          rsp_q;

	logic [IW-1:0] front_d, back_d, wr_addr, rd_addr;
	logic          empty_d, full_now, ok_d, we, re;
	logic [CW-1:0] count_d;

	function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] i);
		return (i == LAST) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [IW-1:0] wrap_dec(input logic [IW-1:0] i);
		return (i == '0) ? LAST : i - 1'b1;
	endfunction

	assign full_now = !empty_q && (count_q >= FULLC);

	always_comb begin
		front_d = front_q;
		back_d  = back_q;
		empty_d = empty_q;
		count_d = count_q;
		ok_d    = 1'b0;
		we      = 1'b0;
		re      = 1'b0;
		wr_addr = '0;
		rd_addr = front_q;
		unique case (req.command)
			CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
				if (!full_now) begin
					if (empty_q) begin
						front_d = '0;
						back_d  = '0;
						wr_addr = '0;
					end else if (req.command == CMD_PUSH_FRONT) begin
						front_d = wrap_dec(front_q);
						wr_addr = front_d;
					end else begin
						back_d  = wrap_inc(back_q);
						wr_addr = back_d;
					end
					empty_d = 1'b0;
					count_d = count_q + 1'b1;
					ok_d    = 1'b1;
					we      = ctl.accept;
				end
			end
			CMD_POP_FRONT, CMD_POP_BACK: begin
				rd_addr = (req.command == CMD_POP_FRONT) ? front_q : back_q;
				if (!empty_q) begin
					if (front_q == back_q) begin
						front_d = '0;
						back_d  = '0;
						empty_d = 1'b1;
					end else if (req.command == CMD_POP_FRONT) begin
						front_d = wrap_inc(front_q);
					end else begin
						back_d = wrap_dec(back_q);
					end
					if (count_q != '0) begin
						count_d = count_q - 1'b1;
					end
					ok_d = 1'b1;
					re   = ctl.accept;
				end
			end
			default: begin
				ok_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			back_q  <= '0;
			empty_q <= 1'b1;
			count_q <= '0;
		end else if (ctl.accept) begin
			front_q <= front_d;
			back_q  <= back_d;
			empty_q <= empty_d;
			count_q <= count_d;
		end
	end

	// slot memory, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= DATA_WIDTH'(req.item_value);
		end
		if (re) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			rsp_q.popped_value <= '0;
			rsp_q.ok           <= ok_d;
			rsp_q.item_count   <= 5'(count_d);
			rsp_q.is_empty     <= empty_d;
			rsp_q.is_full      <= !empty_d && (count_d >= FULLC);
		end else if (ctl.load_pop && rsp_q.ok) begin
			rsp_q.popped_value <= 32'(rd_q);
		end
	end

	assign rsp = rsp_q;

endmodule

`default_nettype wire

FILE: rtl/core/ring_buffer_deque.sv
// ----------------------------------------------------------------------------
// ring_buffer_deque
// Double-ended queue in a circular slot memory: push or pop at either end,
// with a response per request giving the popped word, ok and fill status.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   rbd_pkg::req_t
//   rsp      out        rsp_valid/rsp_stall   rbd_pkg::rsp_t
//
// A pop waits in ST_READ for the registered slot memory read before its
// response is valid. One request is in flight at a time; the next one
// is taken once the response register is free or being taken in the
// same cycle. Reset clears indices, count and empty flag; slot contents
// are not cleared. A stalled response holds its payload until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module ring_buffer_deque #(
	parameter int DEPTH      = rbd_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = rbd_pkg::DATA_WIDTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire rbd_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output rbd_pkg::rsp_t      rsp
);
	import rbd_pkg::*;

	ctl_t ctl;

	rbd_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req_command (req.command),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.ctl         (ctl)
	);

	rbd_datapath #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire

FILE: rtl/core/rbd_checker.sv
// ----------------------------------------------------------------------------
// rbd_checker
// Port-level checks on the deque responses, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rbd_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          req_stall,
	input wire logic          rsp_valid,
	input wire logic          rsp_stall,
	input wire rbd_pkg::rsp_t rsp
);
	import rbd_pkg::*;

	// stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	// a refused request returns no data
	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.ok |-> rsp.popped_value == 32'd0)
		else $error("refused request returned data");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.is_empty |-> rsp.item_count == 5'd0)
		else $error("empty with nonzero count");

	a_full_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.is_full |-> !rsp.is_empty)
		else $error("full and empty together");

	// no request taken while a response is stalled
	a_no_accept_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |-> req_stall)
		else $error("request taken while response stalled");

endmodule

bind ring_buffer_deque rbd_checker u_rbd_checker (.*);

`default_nettype wire
